[design/rgcd_pkg.sv]
// Shared types and constants for the running GCD aggregate.
`timescale 1ns / 1ps
package rgcd_pkg;

   // Width of the ports that carry value bits.
   localparam int PORT_WIDTH  = 64;
   // Number of low value bits that take part in the aggregate.
   localparam int VALUE_WIDTH = 64;
   localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);

   localparam logic ACTION_FOLD  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_WORK,
      TOP_HOLD
   } top_state_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_REDUCE,
      CORE_SCALE
   } core_state_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] gcd;
   } core_rsp_type;

endpackage

[design/running_gcd_aggregate_top.sv]
// Top level of the running GCD aggregate: request handling, aggregate state, result register.
`timescale 1ns / 1ps
// Each request folds one value into a running greatest common divisor, or clears it, and
// returns one response with the current GCD and whether any non-null value was seen. Clear,
// null and first-value requests pass through the hold state into the output register. A value
// folded into an existing aggregate runs through a binary GCD engine that does one shift or
// one 64-bit subtract per cycle. Stripping shared factors of two and reducing the pair
// interleave shifts and subtracts, since every subtract leaves an even operand that must
// then be shifted. Each shared factor of two is restored at the end by one more shift. The
// block takes one request at a time; a new request is accepted while a finished response
// still waits in the output register.
module running_gcd_aggregate_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic                            csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [rgcd_pkg::PORT_WIDTH-1:0] req_value,
   input  logic                            req_value_is_null,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rgcd_pkg::PORT_WIDTH-1:0] rsp_gcd_value,
   output logic                            rsp_has_value
);
   import rgcd_pkg::*;

   top_state_type          state_ff, state_in;
   logic                   signed_ff, signed_in;
   logic                   seen_ff, seen_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PORT_WIDTH-1:0]  rsp_gcd_ff, rsp_gcd_in;
   logic                   rsp_has_ff, rsp_has_in;
   logic [VALUE_WIDTH-1:0] raw_value;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   accept;
   logic                   slot_free;
   logic                   load_rsp;
   logic                   core_start;
   core_rsp_type           core_rsp;

   assign raw_value = req_value[VALUE_WIDTH-1:0];
   assign magnitude = (signed_ff && raw_value[VALUE_WIDTH-1]) ? ('0 - raw_value) : raw_value;
   assign accept    = req_valid && (state_ff == TOP_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   rgcd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .operand_a (div_ff),
      .operand_b (magnitude),
      .core_rsp  (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         signed_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         signed_ff    <= signed_in;
         seen_ff      <= seen_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_gcd_ff <= rsp_gcd_in;
      rsp_has_ff <= rsp_has_in;
   end

   always_comb begin
      state_in   = state_ff;
      seen_in    = seen_ff;
      div_in     = div_ff;
      core_start = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               state_in = TOP_HOLD;
               if (req_action == ACTION_CLEAR) begin
                  seen_in = 1'b0;
                  div_in  = '0;
               end else if (!req_value_is_null) begin
                  if (!seen_ff) begin
                     seen_in = 1'b1;
                     div_in  = magnitude;
                  end else begin
                     // The core samples the magnitude now; requests stay stalled until the block is idle again.
                     core_start = 1'b1;
                     state_in   = TOP_WORK;
                  end
               end
            end
         end
         TOP_WORK: begin
            if (core_rsp.done) begin
               div_in   = core_rsp.gcd;
               state_in = TOP_HOLD;
            end
         end
         TOP_HOLD: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // Requests are stalled whenever the block is not idle; the core samples its operands on the start cycle itself.
   assign req_stall = (state_ff != TOP_IDLE);

   always_comb begin
      signed_in = csr_write_enable ? csr_write_data : signed_ff;
   end

   always_comb begin
      rsp_gcd_in   = rsp_gcd_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_has_in   = seen_ff;
         rsp_gcd_in   = seen_ff ? PORT_WIDTH'(div_ff) : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gcd_value = rsp_gcd_ff;
   assign rsp_has_value = rsp_has_ff;

endmodule

[design/rgcd_core.sv]
// Iterative binary GCD engine with one shared shift and subtract step.
`timescale 1ns / 1ps
module rgcd_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rgcd_pkg::VALUE_WIDTH-1:0] operand_a,
   input  logic [rgcd_pkg::VALUE_WIDTH-1:0] operand_b,
   output rgcd_pkg::core_rsp_type          core_rsp
);
   import rgcd_pkg::*;

   core_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [SHIFT_WIDTH-1:0] k_ff, k_in;
   logic [VALUE_WIDTH:0]   diff_ab;
   logic [VALUE_WIDTH-1:0] diff_ba;
   logic                   done;

   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = b_ff - a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      done     = 1'b0;
      case (state_ff)
         CORE_IDLE: begin
            if (start) begin
               a_in     = operand_a;
               b_in     = operand_b;
               k_in     = '0;
               state_in = CORE_REDUCE;
            end
         end
         CORE_REDUCE: begin
            if (a_ff == '0 || b_ff == '0) begin
               a_in     = a_ff | b_ff;
               state_in = CORE_SCALE;
            end else if (!a_ff[0] && !b_ff[0]) begin
               // Common factors of two are counted and restored at the end.
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + SHIFT_WIDTH'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!diff_ab[VALUE_WIDTH]) begin
               a_in = diff_ab[VALUE_WIDTH-1:0];
            end else begin
               b_in = diff_ba;
            end
         end
         CORE_SCALE: begin
            if (k_ff == '0) begin
               done     = 1'b1;
               state_in = CORE_IDLE;
            end else begin
               a_in = a_ff << 1;
               k_in = k_ff - SHIFT_WIDTH'(1);
            end
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   assign core_rsp.done = done;
   assign core_rsp.gcd  = a_ff;

endmodule

[test/tb_running_gcd_aggregate_top.sv]
// Self-checking testbench for the running GCD aggregate top level.
`timescale 1ns / 1ps
module tb_running_gcd_aggregate_top;
   import rgcd_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_AT_RESULT = 400;
   localparam int HOLD_CYCLES = 400;
   localparam logic [PORT_WIDTH-1:0] VALUE_MASK =
      {PORT_WIDTH{1'b1}} >> (PORT_WIDTH - VALUE_WIDTH);
   localparam logic [PORT_WIDTH-1:0] SIGN_MASK =
      {{(PORT_WIDTH-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1);

   typedef struct packed {
      logic                  action;
      logic [PORT_WIDTH-1:0] value;
      logic                  is_null;
   } gcd_request_type;

   typedef struct packed {
      logic [PORT_WIDTH-1:0] gcd_value;
      logic                  has_value;
   } gcd_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data = 1'b0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACTION_FOLD;
   logic [PORT_WIDTH-1:0] req_value = '0;
   logic                  req_value_is_null = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PORT_WIDTH-1:0] rsp_gcd_value;
   logic                  rsp_has_value;

   gcd_request_type request_queue[$];
   gcd_result_type  expected_gcds[$];

   // Shadow of the aggregate state and the sign mode register.
   logic [PORT_WIDTH-1:0] acc_divisor = '0;
   logic                  acc_seen = 1'b0;
   logic                  signed_mode = 1'b0;

   logic [PORT_WIDTH-1:0] family_base = 64'd6;
   logic                  no_idle = 1'b0;
   int                    errors = 0;
   int                    results_seen = 0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;

   running_gcd_aggregate_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_value_is_null (req_value_is_null),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gcd_value     (rsp_gcd_value),
      .rsp_has_value     (rsp_has_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PORT_WIDTH-1:0] euclid(logic [PORT_WIDTH-1:0] x,
                                                    logic [PORT_WIDTH-1:0] y);
      logic [PORT_WIDTH-1:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // Applies one request to the shadow aggregate and returns the response it should give.
   function automatic gcd_result_type fold_request(gcd_request_type rq);
      logic [PORT_WIDTH-1:0] mag;
      gcd_result_type        res;
      if (rq.action == ACTION_CLEAR) begin
         acc_divisor = '0;
         acc_seen = 1'b0;
      end else if (!rq.is_null) begin
         mag = rq.value & VALUE_MASK;
         if (signed_mode && (mag & SIGN_MASK) != 0) begin
            mag = (-mag) & VALUE_MASK;
         end
         if (!acc_seen) begin
            acc_divisor = mag;
            acc_seen = 1'b1;
         end else begin
            acc_divisor = euclid(acc_divisor, mag);
         end
      end
      res.gcd_value = acc_seen ? acc_divisor : '0;
      res.has_value = acc_seen;
      return res;
   endfunction

   function automatic logic [PORT_WIDTH-1:0] random_value();
      logic [PORT_WIDTH-1:0] v;
      int                    w;
      case ($urandom_range(9))
         0: v = {$urandom, $urandom};
         1: begin
            w = $urandom_range(64, 1);
            v = {$urandom, $urandom} >> (64 - w);
         end
         2: begin
            case ($urandom_range(3))
               0: v = '0;
               1: v = '1;
               2: v = SIGN_MASK;
               default: v = 64'd1;
            endcase
         end
         default: v = (family_base * $urandom_range(1000, 1)) << $urandom_range(8, 0);
      endcase
      // Negative values matter in signed mode and act as large values otherwise.
      if ($urandom_range(3) == 0) begin
         v = -v;
      end
      return v;
   endfunction

   task automatic push_request(input logic action, input logic [PORT_WIDTH-1:0] value,
                               input logic is_null);
      gcd_request_type rq;
      rq.action = action;
      rq.value = value;
      rq.is_null = is_null;
      request_queue.push_back(rq);
   endtask

   // Mostly runs of folds over multiples of a shared factor, broken by clears and nulls.
   task automatic push_random(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            family_base = (({$urandom, $urandom} >> $urandom_range(63, 20)) | 64'd1)
                          << $urandom_range(12, 0);
            push_request(ACTION_CLEAR, {$urandom, $urandom}, 1'($urandom));
         end else if (pick < 16) begin
            push_request(ACTION_FOLD, {$urandom, $urandom}, 1'b1);
         end else begin
            push_request(ACTION_FOLD, random_value(), 1'b0);
         end
      end
   endtask

   task automatic set_mode(input logic signed_setting, input logic quiet);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= signed_setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      signed_mode = signed_setting;
      no_idle = quiet;
   endtask

   // Waits until every queued request has been sent and has its response.
   task automatic drain();
      @(negedge clock);
      while (request_queue.size() != 0 || req_valid || expected_gcds.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : request_driver
      gcd_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rq.action = req_action;
            rq.value = req_value;
            rq.is_null = req_value_is_null;
            expected_gcds.push_back(fold_request(rq));
         end
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && (no_idle || $urandom_range(99) >= 32)) begin
               rq = request_queue.pop_front();
               req_valid <= 1'b1;
               req_action <= rq.action;
               req_value <= rq.value;
               req_value_is_null <= rq.is_null;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      gcd_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_gcds.size() == 0) begin
               $display("%0t: response with no request waiting: gcd_value %h has_value %b",
                        $time, rsp_gcd_value, rsp_has_value);
               errors++;
            end else begin
               want = expected_gcds.pop_front();
               if (rsp_gcd_value !== want.gcd_value) begin
                  $display("%0t: gcd_value mismatch: expected %h, actual %h",
                           $time, want.gcd_value, rsp_gcd_value);
                  errors++;
               end
               if (rsp_has_value !== want.has_value) begin
                  $display("%0t: has_value mismatch: expected %b, actual %b",
                           $time, want.has_value, rsp_has_value);
                  errors++;
               end
            end
            results_seen++;
            // One long hold-off so the block fills up and stalls the sender.
            if (results_seen == HOLD_AT_RESULT) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 32);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Unsigned corner cases: empty aggregate, zeros, clears and the top bit.
      set_mode(1'b0, 1'b0);
      push_request(ACTION_FOLD, '1, 1'b1);
      push_request(ACTION_FOLD, 64'd0, 1'b0);
      push_request(ACTION_FOLD, 64'd0, 1'b0);
      push_request(ACTION_FOLD, 64'd12, 1'b0);
      push_request(ACTION_FOLD, 64'd18, 1'b0);
      push_request(ACTION_FOLD, 64'd5, 1'b1);
      push_request(ACTION_FOLD, 64'd0, 1'b0);
      push_request(ACTION_CLEAR, '1, 1'b1);
      push_request(ACTION_FOLD, '1, 1'b0);
      push_request(ACTION_FOLD, SIGN_MASK, 1'b0);
      push_request(ACTION_CLEAR, 64'd9, 1'b0);
      push_request(ACTION_FOLD, SIGN_MASK, 1'b0);
      push_request(ACTION_FOLD, 64'h4000_0000_0000_0000, 1'b0);
      push_request(ACTION_FOLD, 64'd3 << 40, 1'b0);
      drain();

      // Signed corner cases: the most negative value and small negatives.
      set_mode(1'b1, 1'b0);
      push_request(ACTION_CLEAR, 64'd0, 1'b0);
      push_request(ACTION_FOLD, SIGN_MASK, 1'b0);
      push_request(ACTION_FOLD, -64'd6, 1'b0);
      push_request(ACTION_FOLD, '1, 1'b0);
      push_request(ACTION_CLEAR, SIGN_MASK, 1'b1);
      push_request(ACTION_FOLD, -64'd12, 1'b0);
      push_request(ACTION_FOLD, 64'd18, 1'b0);
      push_request(ACTION_FOLD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      push_request(ACTION_FOLD, -64'd3, 1'b1);
      push_request(ACTION_FOLD, 64'd0, 1'b0);
      drain();

      set_mode(1'b0, 1'b0);
      push_random(400);
      drain();

      set_mode(1'b1, 1'b1);
      push_random(350);
      drain();

      set_mode(1'b0, 1'b0);
      push_random(250);
      drain();

      set_mode(1'b1, 1'b0);
      push_random(350);
      drain();

      repeat (300) @(posedge clock);
      errors += expected_gcds.size();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
design/rgcd_pkg.sv
design/rgcd_core.sv
design/running_gcd_aggregate_top.sv
test/tb_running_gcd_aggregate_top.sv
